@@ design/cwr_pkg.sv @@
// Shared constants, codes and interface types of the convolution window range engine.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cwr_pkg;

   // Default width to which result indices are masked.
   localparam int INDEX_BITS_DEFAULT = 16;

   // Field widths fixed by the interface.
   localparam int ModeBits   = 2;
   localparam int IndexWidth = 16;
   localparam int TapBits    = 8;
   localparam int ReqDataBits = 48;
   localparam int RspDataBits = 32;

   // Register write port.
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 16;

   localparam logic [CsrAddrBits-1:0] CSR_STRIDE      = 3'd0;
   localparam logic [CsrAddrBits-1:0] CSR_KERNEL_SIZE = 3'd1;
   localparam logic [CsrAddrBits-1:0] CSR_PADDING     = 3'd2;
   localparam logic [CsrAddrBits-1:0] CSR_INPUT_SIZE  = 3'd3;
   localparam logic [CsrAddrBits-1:0] CSR_FRACTIONAL  = 3'd4;

   // Query kinds.
   localparam logic [ModeBits-1:0] MODE_INDEX  = 2'd0;
   localparam logic [ModeBits-1:0] MODE_INPUT  = 2'd1;
   localparam logic [ModeBits-1:0] MODE_OUTPUT = 2'd2;

   // Datapath widths: dividend of the serial divider, its step counter,
   // signed tap sums, stride products and mapped indices.
   localparam int DivBits      = 17;
   localparam int DivCountBits = 5;
   localparam int SumBits      = 19;
   localparam int ProdBits     = 24;
   localparam int MapBits      = 26;

   typedef struct packed {
      logic load_req;
      logic div_lo_start;
      logic take_lo;
      logic div_hi_start;
      logic take_hi;
      logic clamp;
      logic scale;
      logic merge;
      logic map0;
      logic next_tap;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic [ModeBits-1:0] mode;
      logic                frac;
      logic                range_ok;
      logic                l_neg;
      logic                h_neg;
      logic                last_tap;
      logic                div_done;
   } status_type;

endpackage

`default_nettype wire

@@ design/cwr_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for non-negative dividends.
// Uses widths from cwr_pkg; instantiated by cwr_datapath.
`default_nettype none

module cwr_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cwr_pkg::DivBits-1:0] dividend,
   input  wire logic [7:0]                  divisor,
   output logic                             done,
   output logic [cwr_pkg::DivBits-1:0]      quotient,
   output logic                             rem_nonzero
);

   logic [cwr_pkg::DivCountBits-1:0] count_ff, count_in;
   logic [cwr_pkg::DivBits-1:0]      quo_ff, quo_in;
   logic [7:0]                       rem_ff, rem_in;
   logic [7:0]                       dsr_ff, dsr_in;
   logic [8:0]                       trial;
   logic [8:0]                       diff;
   logic                             fits;

   // The partial remainder stays below the divisor, so eight bits hold it.
   assign trial = {rem_ff, quo_ff[cwr_pkg::DivBits-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         count_in = cwr_pkg::DivCountBits'(cwr_pkg::DivBits);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quo_in   = {quo_ff[cwr_pkg::DivBits-2:0], fits};
         rem_in   = fits ? diff[7:0] : trial[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done        = (count_ff == '0);
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire

@@ design/cwr_datapath.sv @@
// Datapath: configuration registers, per-tap bounds, stride products and result merge.
// Depends on cwr_pkg and cwr_divider; driven by commands from cwr_ctrl.
`default_nettype none

module cwr_datapath #(
   parameter int INDEX_BITS = cwr_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [cwr_pkg::CsrAddrBits-1:0] csr_addr,
   input  wire logic [cwr_pkg::CsrDataBits-1:0] csr_wdata,
   input  wire logic [cwr_pkg::ModeBits-1:0]    req_mode,
   input  wire logic [cwr_pkg::IndexWidth-1:0]  req_output_begin,
   input  wire logic [cwr_pkg::IndexWidth-1:0]  req_output_end,
   input  wire logic [cwr_pkg::TapBits-1:0]     req_kernel_begin,
   input  wire logic [cwr_pkg::TapBits-1:0]     req_kernel_end,
   input  wire cwr_pkg::cmd_type                cmd,
   output cwr_pkg::status_type                  status,
   output logic                                 rsp_found,
   output logic [cwr_pkg::IndexWidth-1:0]       rsp_range_begin,
   output logic [cwr_pkg::IndexWidth-1:0]       rsp_range_end
);

   localparam int IW = cwr_pkg::IndexWidth;
   localparam int SB = cwr_pkg::SumBits;
   localparam int PB = cwr_pkg::ProdBits;
   localparam int MB = cwr_pkg::MapBits;
   localparam int DB = cwr_pkg::DivBits;
   localparam logic [IW-1:0] IdxMask =
      (INDEX_BITS >= IW) ? {IW{1'b1}} : IW'((64'd1 << INDEX_BITS) - 64'd1);

   // Configuration.
   logic [7:0]    stride_ff, kernel_size_ff, padding_ff;
   logic [IW-1:0] input_size_ff;
   logic          fractional_ff;

   // Query and per-tap working registers.
   logic [cwr_pkg::ModeBits-1:0] mode_ff;
   logic [IW-1:0] ob_ff, oe_ff;
   logic [7:0]    ke_ff, k_ff, k_in;
   logic [DB-1:0] q_lo_ff, q_hi_ff;
   logic          lo_rnz_ff;
   logic [IW-1:0] lo_ff, lo_in, hi_ff;
   logic          empty_ff;
   logic [PB-1:0] prod_lo_ff, prod_hi_ff;
   logic          have_ff, have_in;
   logic [IW-1:0] rb_ff, rb_in, re_ff, re_in;
   logic          found_ff;
   logic [IW-1:0] out_begin_ff, out_end_ff;

   logic [7:0]          s_eff;
   logic signed [SB-1:0] p_w, k_w, ks_w, ob_w, oe_w, n_w;
   logic signed [SB-1:0] c_w, pk_w, l_w, h_w, g_w;
   logic [MB-1:0]       g_ext;
   logic [DB-1:0]       div_dividend, div_quotient;
   logic                div_done, div_rnz;

   logic [DB:0]   lo_raw, lo_c, lo_floor;
   logic [IW-1:0] hi_cap, hi_c;
   logic          empty_c;
   logic          mul_sel;
   logic [MB-1:0] vlo_w, vhi_w, idx_w;
   logic [IW-1:0] vlo, vhi, idx0;
   logic [IW:0]   vhi_p1;
   logic          found0;

   assign s_eff = (stride_ff == 8'd0) ? 8'd1 : stride_ff;

   // Signed tap arithmetic. In the transposed form c is the offset from an
   // output position to the stretched input position that tap k lands on.
   assign p_w  = SB'(padding_ff);
   assign k_w  = SB'(k_ff);
   assign ks_w = SB'(kernel_size_ff);
   assign ob_w = SB'(ob_ff);
   assign oe_w = SB'(oe_ff);
   assign n_w  = SB'(input_size_ff);
   assign c_w  = p_w - ks_w + SB'(1) + k_w;
   assign pk_w = p_w - k_w;
   assign l_w  = fractional_ff ? (ob_w + c_w) : pk_w;
   assign h_w  = fractional_ff ? (oe_w - SB'(1) + c_w) : (n_w - SB'(1) + pk_w);
   assign g_w  = fractional_ff ? c_w : pk_w;
   assign g_ext = {{(MB-SB){g_w[SB-1]}}, g_w};

   // A non-positive lower numerator has a ceiling quotient of at most zero,
   // which the clamp below discards anyway, so it is divided as zero.
   always_comb begin
      div_dividend = h_w[DB-1:0];
      if (cmd.div_lo_start) begin
         div_dividend = (!l_w[SB-1] && (l_w != '0)) ? l_w[DB-1:0] : '0;
      end
   end

   cwr_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_lo_start | cmd.div_hi_start),
      .dividend    (div_dividend),
      .divisor     (s_eff),
      .done        (div_done),
      .quotient    (div_quotient),
      .rem_nonzero (div_rnz)
   );

   // Clamp the per-tap quotients to the requested window or the input extent.
   assign lo_raw   = {1'b0, q_lo_ff} + (DB+1)'(lo_rnz_ff);
   assign lo_floor = fractional_ff ? '0 : (DB+1)'(ob_ff);
   assign lo_c     = (lo_raw > lo_floor) ? lo_raw : lo_floor;
   assign hi_cap   = fractional_ff ? (input_size_ff - 1'b1) : (oe_ff - 1'b1);
   assign hi_c     = (q_hi_ff > DB'(hi_cap)) ? hi_cap : q_hi_ff[IW-1:0];
   assign empty_c  = lo_c > (DB+1)'(hi_c);

   // Input-range queries in normal form and output-range queries in the
   // transposed form need the quotient scaled back by the stride.
   assign mul_sel = fractional_ff ? (mode_ff == cwr_pkg::MODE_OUTPUT)
                                  : (mode_ff == cwr_pkg::MODE_INPUT);
   assign vlo_w  = MB'(prod_lo_ff) - g_ext;
   assign vhi_w  = MB'(prod_hi_ff) - g_ext;
   assign vlo    = mul_sel ? vlo_w[IW-1:0] : lo_ff;
   assign vhi    = mul_sel ? vhi_w[IW-1:0] : hi_ff;
   assign vhi_p1 = (IW+1)'(vhi) + 1'b1;

   // Single index lookup.
   assign idx_w  = vlo_w;
   assign found0 = fractional_ff ? (!lo_rnz_ff && (q_lo_ff < DB'(input_size_ff)))
                                 : (!idx_w[MB-1] && (idx_w < MB'(input_size_ff)));
   assign idx0   = fractional_ff ? q_lo_ff[IW-1:0] : idx_w[IW-1:0];

   always_comb begin
      k_in    = k_ff;
      lo_in   = lo_ff;
      have_in = have_ff;
      rb_in   = rb_ff;
      re_in   = re_ff;
      if (cmd.load_req) begin
         k_in    = req_kernel_begin;
         lo_in   = req_output_begin;
         have_in = 1'b0;
         rb_in   = '0;
         re_in   = '0;
      end
      if (cmd.next_tap) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.clamp) begin
         lo_in = lo_c[IW-1:0];
      end
      if (cmd.map0 && found0) begin
         have_in = 1'b1;
         rb_in   = idx0;
         re_in   = idx0 + 1'b1;
      end
      if (cmd.merge && !empty_ff) begin
         have_in = 1'b1;
         if (mode_ff == cwr_pkg::MODE_INPUT) begin
            if (!have_ff) begin
               rb_in = vlo;
            end
            re_in = vhi_p1[IW-1:0];
         end else begin
            if (!have_ff || (vlo < rb_ff)) begin
               rb_in = vlo;
            end
            if (!have_ff || (vhi_p1 > (IW+1)'(re_ff))) begin
               re_in = vhi_p1[IW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff      <= 8'd1;
         kernel_size_ff <= 8'd1;
         padding_ff     <= 8'd0;
         input_size_ff  <= '0;
         fractional_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            cwr_pkg::CSR_STRIDE:      stride_ff      <= csr_wdata[7:0];
            cwr_pkg::CSR_KERNEL_SIZE: kernel_size_ff <= csr_wdata[7:0];
            cwr_pkg::CSR_PADDING:     padding_ff     <= csr_wdata[7:0];
            cwr_pkg::CSR_INPUT_SIZE:  input_size_ff  <= csr_wdata[IW-1:0];
            cwr_pkg::CSR_FRACTIONAL:  fractional_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         ob_ff   <= req_output_begin;
         oe_ff   <= req_output_end;
         ke_ff   <= req_kernel_end;
      end
      if (cmd.take_lo) begin
         q_lo_ff   <= div_quotient;
         lo_rnz_ff <= div_rnz;
      end
      if (cmd.take_hi) begin
         q_hi_ff <= div_quotient;
      end
      if (cmd.clamp) begin
         hi_ff    <= hi_c;
         empty_ff <= empty_c;
      end
      if (cmd.scale) begin
         prod_lo_ff <= PB'(lo_ff) * PB'(s_eff);
         prod_hi_ff <= PB'(hi_ff) * PB'(s_eff);
      end
      if (cmd.publish) begin
         found_ff     <= have_ff;
         out_begin_ff <= rb_ff & IdxMask;
         out_end_ff   <= re_ff & IdxMask;
      end
      k_ff    <= k_in;
      lo_ff   <= lo_in;
      have_ff <= have_in;
      rb_ff   <= rb_in;
      re_ff   <= re_in;
   end

   assign status.mode     = mode_ff;
   assign status.frac     = fractional_ff;
   assign status.range_ok = (ob_ff < oe_ff) && (k_ff < ke_ff) && (input_size_ff != '0);
   assign status.l_neg    = l_w[SB-1];
   assign status.h_neg    = h_w[SB-1];
   assign status.last_tap = ((9'(k_ff) + 9'd1) == 9'(ke_ff));
   assign status.div_done = div_done;

   assign rsp_found       = found_ff;
   assign rsp_range_begin = out_begin_ff;
   assign rsp_range_end   = out_end_ff;

endmodule

`default_nettype wire

@@ design/cwr_ctrl.sv @@
// Controller: sequences a query over kernel taps and the shared divider, owns the handshakes.
// Depends on cwr_pkg; issues commands to cwr_datapath and reads its status.
`default_nettype none

module cwr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                rsp_tready,
   input  wire cwr_pkg::status_type status,
   output cwr_pkg::cmd_type         cmd,
   output logic                     req_tready,
   output logic                     rsp_tvalid
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_CHECK   = 11'b000_0000_0010,
      ST_LO_GO   = 11'b000_0000_0100,
      ST_LO_WAIT = 11'b000_0000_1000,
      ST_HI_GO   = 11'b000_0001_0000,
      ST_HI_WAIT = 11'b000_0010_0000,
      ST_CLAMP   = 11'b000_0100_0000,
      ST_SCALE   = 11'b000_1000_0000,
      ST_MERGE   = 11'b001_0000_0000,
      ST_MAP0    = 11'b010_0000_0000,
      ST_FINISH  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (status.mode) inside
               cwr_pkg::MODE_INDEX: begin
                  if (!status.frac) begin
                     cmd.scale = 1'b1;
                     state_in  = ST_SCALE;
                  end else if (status.l_neg) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_LO_GO;
                  end
               end
               cwr_pkg::MODE_INPUT, cwr_pkg::MODE_OUTPUT: begin
                  state_in = status.range_ok ? ST_LO_GO : ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_LO_GO: begin
            cmd.div_lo_start = 1'b1;
            state_in         = ST_LO_WAIT;
         end
         ST_LO_WAIT: begin
            if (status.div_done) begin
               cmd.take_lo = 1'b1;
               state_in    = (status.mode == cwr_pkg::MODE_INDEX) ? ST_MAP0 : ST_HI_GO;
            end
         end
         ST_HI_GO: begin
            // A negative upper numerator leaves this tap without any output.
            if (!status.h_neg) begin
               cmd.div_hi_start = 1'b1;
               state_in         = ST_HI_WAIT;
            end else if (status.last_tap) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_tap = 1'b1;
               state_in     = ST_LO_GO;
            end
         end
         ST_HI_WAIT: begin
            if (status.div_done) begin
               cmd.take_hi = 1'b1;
               state_in    = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = (status.mode == cwr_pkg::MODE_INDEX) ? ST_MAP0 : ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.last_tap) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_tap = 1'b1;
               state_in     = ST_LO_GO;
            end
         end
         ST_MAP0: begin
            cmd.map0 = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/conv_window_range_engine.sv @@
// Top level of the convolution window range engine: channel packing and module wiring.
// Depends on cwr_pkg, cwr_ctrl and cwr_datapath (which holds cwr_divider).
//
//   channel | direction | payload
//   --------+-----------+----------------------------------------------------------
//   req_    | in        | tdata: output_begin, output_end, kernel_begin, kernel_end;
//           |           | tuser: mode
//   rsp_    | out       | tdata: range_begin, range_end; tuser: found
//   csr_    | in        | write enable, register index, write data
//
// A single index query makes at most one divider pass in transposed form and none in normal form.
// Range queries work through each kernel tap in the range in turn: each tap makes up to
// two passes of 17 steps through the one radix-2 divider. One query is in flight at a time.
// Reset is synchronous and clears the registers to stride 1, one tap, no padding.
// A finished result waits in the output register; the next query is taken meanwhile.
`default_nettype none

module conv_window_range_engine #(
   parameter int INDEX_BITS = cwr_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cwr_pkg::CsrAddrBits-1:0]  csr_addr,
   input  wire logic [cwr_pkg::CsrDataBits-1:0]  csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [15:0] output_begin, [31:16] output_end,
   // [39:32] kernel_begin, [47:40] kernel_end
   input  wire logic [cwr_pkg::ReqDataBits-1:0]  req_tdata,
   // [1:0] mode
   input  wire logic [cwr_pkg::ModeBits-1:0]     req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] range_begin, [31:16] range_end
   output logic [cwr_pkg::RspDataBits-1:0]       rsp_tdata,
   // [0] found
   output logic                                  rsp_tuser
);

   cwr_pkg::cmd_type    cmd;
   cwr_pkg::status_type status;
   logic [cwr_pkg::IndexWidth-1:0] range_begin, range_end;

   cwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   cwr_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_tuser),
      .req_output_begin (req_tdata[15:0]),
      .req_output_end   (req_tdata[31:16]),
      .req_kernel_begin (req_tdata[39:32]),
      .req_kernel_end   (req_tdata[47:40]),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_tuser),
      .rsp_range_begin  (range_begin),
      .rsp_range_end    (range_end)
   );

   assign rsp_tdata = {range_end, range_begin};

endmodule

`default_nettype wire

@@ design/cwr_checker.sv @@
// Port-level checks for the convolution window range engine, bound to its top level.
// Depends only on the widths in cwr_pkg.
`default_nettype none

module cwr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cwr_pkg::RspDataBits-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);

   // A result waiting for the sink keeps its contents.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // No result is pending straight after reset.
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   // A query that finds nothing reports a zero range.
   property p_empty_zero;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0;
   endproperty
   a_empty_zero: assert property (p_empty_zero) else $error("empty result with non-zero range");

   // Only one query is worked on at a time.
   property p_one_at_a_time;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready |=> !req_tready;
   endproperty
   a_one_at_a_time: assert property (p_one_at_a_time) else $error("second query taken at once");

endmodule

bind conv_window_range_engine cwr_checker u_cwr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
